>>> src/sorted_timestamp_table_macros.svh
// Assertion macros shared by the sorted timestamp table RTL
`ifndef SORTED_TIMESTAMP_TABLE_MACROS_SVH
`define SORTED_TIMESTAMP_TABLE_MACROS_SVH

// Check a property in the same cycle as its trigger
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a property in the cycle after its trigger
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/stt_pkg.sv
// Types, constants and decode helpers for the sorted timestamp table
`default_nettype none
package stt_pkg;
	localparam int DEPTH        = 1024;
	localparam int KEY_BITS     = 48;
	localparam int PAYLOAD_BITS = 64;
	localparam int AW           = $clog2(DEPTH);
	localparam int CW           = $clog2(DEPTH + 1);
	localparam int IW           = CW + 1;
	localparam int QDEPTH       = 4;
	localparam int QAW          = $clog2(QDEPTH);
	localparam int QCW          = $clog2(QDEPTH + 1);

	// operation codes on the request channel
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_FIND_X = 3'd1;
	localparam logic [2:0] OP_FIND_F = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_UPSERT = 3'd4;
	localparam logic [2:0] OP_LOOKUP = 3'd5;

	// command classes handed to the engine
	localparam logic [2:0] K_CLEAR  = 3'd0;
	localparam logic [2:0] K_FIND_X = 3'd1;
	localparam logic [2:0] K_FIND_F = 3'd2;
	localparam logic [2:0] K_INSERT = 3'd3;
	localparam logic [2:0] K_UPSERT = 3'd4;
	localparam logic [2:0] K_LOOKUP = 3'd5;
	localparam logic [2:0] K_BAD    = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]              kind;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] data;
		logic                    flag;
	} cmd_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] data;
		logic                    flag;
	} rec_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [AW-1:0]           position;
		logic [PAYLOAD_BITS-1:0] data_out;
		logic [CW-1:0]           entry_count;
	} res_t;

	function automatic logic [2:0] classify(input logic [2:0] op);
		logic [2:0] k;
		case (op)
			OP_CLEAR:  k = K_CLEAR;
			OP_FIND_X: k = K_FIND_X;
			OP_FIND_F: k = K_FIND_F;
			OP_INSERT: k = K_INSERT;
			OP_UPSERT: k = K_UPSERT;
			OP_LOOKUP: k = K_LOOKUP;
			default:   k = K_BAD;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

>>> src/stt_req_if.sv
// Request channel: one operation beat
`default_nettype none
interface stt_req_if import stt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              operation;
	logic [KEY_BITS-1:0]     timestamp;
	logic [PAYLOAD_BITS-1:0] payload;
	logic                    period_done;

	modport source(output valid, operation, timestamp, payload, period_done, input ready);
	modport sink(input valid, operation, timestamp, payload, period_done, output ready);
endinterface
`default_nettype wire

>>> src/stt_rsp_if.sv
// Response channel: one result beat
`default_nettype none
interface stt_rsp_if import stt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [AW-1:0]           position;
	logic [PAYLOAD_BITS-1:0] data_out;
	logic [CW-1:0]           entry_count;

	modport source(output valid, status, position, data_out, entry_count, input ready);
	modport sink(input valid, status, position, data_out, entry_count, output ready);
endinterface
`default_nettype wire

>>> src/stt_front.sv
// Front end: accept request beats, classify them and queue commands
`default_nettype none
`include "sorted_timestamp_table_macros.svh"
module stt_front import stt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_req_if.sink   req,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);
	cmd_t           q_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign req.ready = (cnt_q != QCW'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rd_ptr_q];

	// store the classified beat
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= '{kind: classify(req.operation), key: req.timestamp,
				data: req.payload, flag: req.period_done};
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop) cnt_q <= cnt_q + QCW'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCW'(1);
		end
	end

	`STT_ASSERT_SAME(a_occ_bound, 1'b1, cnt_q <= QCW'(QDEPTH), "queue overfilled")
	`STT_ASSERT_NEXT(a_push_grow, push && !pop, cnt_q == $past(cnt_q) + QCW'(1), "push lost")
	`STT_ASSERT_NEXT(a_pop_drop, pop && !push, cnt_q == $past(cnt_q) - QCW'(1), "pop lost")
endmodule
`default_nettype wire

>>> src/stt_engine.sv
// Back end: binary search, shifting insert and the result register
`default_nettype none
`include "sorted_timestamp_table_macros.svh"
module stt_engine import stt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	stt_rsp_if.source  rsp
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LAST   = 4'd1;
	localparam logic [3:0] S_LASTCK = 4'd2;
	localparam logic [3:0] S_PROBE  = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_SHIFT  = 4'd5;
	localparam logic [3:0] S_PUT    = 4'd6;
	localparam logic [3:0] S_FETCH  = 4'd7;
	localparam logic [3:0] S_FGOT   = 4'd8;

	rec_t                 mem_q [DEPTH];
	rec_t                 rd_data_q;
	logic [3:0]           state_q;
	cmd_t                 cmd_q;
	logic signed [IW-1:0] l_q;
	logic signed [IW-1:0] u_q;
	logic signed [IW-1:0] mid_q;
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        sh_k_q;
	logic                 sh_pend_q;
	logic [CW-1:0]        rec_count_q;
	res_t                 res_q;
	logic                 res_valid_q;

	logic [AW-1:0]        rd_addr;
	logic                 we;
	logic [AW-1:0]        wa;
	rec_t                 wd;
	rec_t                 new_rec;
	logic [IW-1:0]        lu_sum;
	logic signed [IW-1:0] mid_c;
	logic signed [IW-1:0] lm1;
	logic signed [IW-1:0] cnt_m1;
	logic                 full;

	assign new_rec   = '{key: cmd_q.key, data: cmd_q.data, flag: cmd_q.flag};
	assign lu_sum    = l_q + u_q;
	assign mid_c     = {1'b0, lu_sum[IW-1:1]};
	assign lm1       = l_q - IW'(1);
	assign cnt_m1    = $signed({1'b0, rec_count_q}) - IW'(1);
	assign full      = (rec_count_q >= CW'(DEPTH));
	assign cmd_ready = (state_q == S_IDLE) && !res_valid_q;

	assign rsp.valid       = res_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.position    = res_q.position;
	assign rsp.data_out    = res_q.data_out;
	assign rsp.entry_count = res_q.entry_count;

	// select memory read and write ports
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wa      = '0;
		wd      = new_rec;
		case (state_q)
			S_LAST:  rd_addr = cnt_m1[AW-1:0];
			S_PROBE: rd_addr = mid_c[AW-1:0];
			S_CMP: begin
				if (cmd_q.kind == K_UPSERT && rd_data_q.key == cmd_q.key) begin
					we = 1'b1;
					wa = mid_q[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (sh_k_q != pos_q) rd_addr = sh_k_q - AW'(1);
				if (sh_pend_q) begin
					we = 1'b1;
					wa = sh_k_q + AW'(1);
					wd = rd_data_q;
				end
			end
			S_PUT: begin
				we = 1'b1;
				wa = pos_q;
			end
			S_FETCH: rd_addr = pos_q;
			default: rd_addr = '0;
		endcase
	end

	// record memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_data_q <= mem_q[rd_addr];
	end

	// sequence one command at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rec_count_q <= '0;
			res_valid_q <= 1'b0;
			cmd_q       <= '0;
			l_q         <= '0;
			u_q         <= '0;
			mid_q       <= '0;
			pos_q       <= '0;
			sh_k_q      <= '0;
			sh_pend_q   <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && rsp.ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd;
						l_q   <= '0;
						u_q   <= cnt_m1;
						mid_q <= -IW'(1);
						case (cmd.kind)
							K_CLEAR: begin
								rec_count_q <= '0;
								res_q       <= '{ST_OK, '0, '0, '0};
								res_valid_q <= 1'b1;
							end
							K_FIND_X, K_FIND_F: begin
								if (rec_count_q == '0) begin
									res_q       <= '{ST_MISS, '0, '0, rec_count_q};
									res_valid_q <= 1'b1;
								end else begin
									state_q <= S_LAST;
								end
							end
							K_INSERT, K_UPSERT, K_LOOKUP: state_q <= S_PROBE;
							default: begin
								res_q       <= '{ST_MISS, '0, '0, rec_count_q};
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_LAST: state_q <= S_LASTCK;
				S_LASTCK: begin
					// skip an unfinished last record
					if (!rd_data_q.flag) u_q <= cnt_m1 - IW'(1);
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (l_q <= u_q) begin
						mid_q   <= mid_c;
						state_q <= S_CMP;
					end else begin
						case (cmd_q.kind)
							K_FIND_F: begin
								pos_q   <= (!mid_q[IW-1] && mid_q != '0) ? lm1[AW-1:0] : '0;
								state_q <= S_FETCH;
							end
							K_INSERT, K_UPSERT: begin
								if (full) begin
									res_q       <= '{ST_FULL, '0, '0, rec_count_q};
									res_valid_q <= 1'b1;
									state_q     <= S_IDLE;
								end else begin
									pos_q     <= l_q[AW-1:0];
									sh_k_q    <= rec_count_q[AW-1:0];
									sh_pend_q <= 1'b0;
									state_q   <= S_SHIFT;
								end
							end
							default: begin
								res_q       <= '{ST_MISS, '0, '0, rec_count_q};
								res_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						endcase
					end
				end
				S_CMP: begin
					if (cmd_q.key < rd_data_q.key) begin
						u_q     <= mid_q - IW'(1);
						state_q <= S_PROBE;
					end else if (cmd_q.key > rd_data_q.key) begin
						l_q     <= mid_q + IW'(1);
						state_q <= S_PROBE;
					end else begin
						case (cmd_q.kind)
							K_UPSERT: begin
								res_q       <= '{ST_OK, mid_q[AW-1:0], cmd_q.data, rec_count_q};
								res_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
							K_INSERT: begin
								if (full) begin
									res_q       <= '{ST_FULL, '0, '0, rec_count_q};
									res_valid_q <= 1'b1;
									state_q     <= S_IDLE;
								end else begin
									pos_q     <= mid_q[AW-1:0];
									sh_k_q    <= rec_count_q[AW-1:0];
									sh_pend_q <= 1'b0;
									state_q   <= S_SHIFT;
								end
							end
							default: begin
								res_q <= '{ST_OK, mid_q[AW-1:0], rd_data_q.data, rec_count_q};
								res_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// move one record up per cycle, top down
					if (sh_k_q != pos_q) begin
						sh_k_q    <= sh_k_q - AW'(1);
						sh_pend_q <= 1'b1;
					end else begin
						sh_pend_q <= 1'b0;
						state_q   <= S_PUT;
					end
				end
				S_PUT: begin
					rec_count_q <= rec_count_q + CW'(1);
					res_q       <= '{ST_OK, pos_q, cmd_q.data, rec_count_q + CW'(1)};
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FETCH: state_q <= S_FGOT;
				S_FGOT: begin
					res_q       <= '{ST_OK, pos_q, rd_data_q.data, rec_count_q};
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STT_ASSERT_SAME(a_count_bound, 1'b1, rec_count_q <= CW'(DEPTH), "record count overflow")
	`STT_ASSERT_SAME(a_full_status, res_valid_q && res_q.status == ST_FULL,
		rec_count_q == CW'(DEPTH), "full status with room left")
	`STT_ASSERT_SAME(a_shift_range, state_q == S_SHIFT, sh_k_q >= pos_q,
		"shift ran below insert point")
endmodule
`default_nettype wire

>>> src/sorted_timestamp_table.sv
// Top level of the sorted timestamp table
// A table of up to 1024 records kept in ascending timestamp order in one
// single-port-read, single-port-write memory. Requests are queued (four deep)
// in front of a sequencer that handles one operation at a time. Clear and
// undefined codes are answered from the idle state; a find, lookup or
// update runs a binary search of at most 11 probes, each a memory read and
// a compare; an insert adds a shift of one record per cycle above the
// insert point, and a find first checks the last record. The memory has
// one read and one write port. A result stays in its output register until
// taken while further requests keep queueing.
`default_nettype none
module sorted_timestamp_table import stt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	stt_req_if.sink   req,
	stt_rsp_if.source rsp
);
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	stt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire
